FILE: rtl/ashk_pkg.sv
package ashk_pkg;

  localparam int AXIS_W     = 16;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_THR  = CFG_IDX_W'(1);

  localparam logic [AXIS_W-1:0]  CHANGE_THR_RST = AXIS_W'(1000);
  localparam logic [COUNT_W-1:0] COUNT_THR_RST  = COUNT_W'(4);

  typedef struct packed {
    logic [AXIS_W-1:0] accel_x;
    logic [AXIS_W-1:0] accel_y;
    logic [AXIS_W-1:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic               shake_detected;
    logic [COUNT_W-1:0] change_count;
  } result_t;

  typedef struct packed {
    logic [AXIS_W-1:0]  change_threshold;
    logic [COUNT_W-1:0] count_threshold;
  } cfg_t;

endpackage

FILE: rtl/accel_shake_detector.sv
// Shake detector for a three-axis accelerometer stream.
// sample channel: sample_valid / sample_stall carry one sample item
// (accel_x, accel_y, accel_z); it is taken at an edge with valid high and
// stall low. result channel: result_valid / result_stall carry one result
// item (shake_detected, change_count) per sample, in order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
// is change_threshold, index 1 is count_threshold, other indexes are
// ignored. cfg_ready is always high; write only while no item is in flight.
// A sample passes two register stages (input register, result register);
// result_stall can hold it in either stage.
// Throughput: one item per cycle while result_stall is low; the per-sample mean,
// flag and count update is one combinational pass between the two registers.
// When result_stall is high the result register holds, the input register
// holds its item, and sample_stall rises only once both are full.
// Reset clears the means, the flag ring, the ring position and both
// stages, and loads change_threshold = 1000 and count_threshold = 4.
module accel_shake_detector #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  ashk_pkg::sample_t                   sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output ashk_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ashk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ashk_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ashk_pkg::*;

  cfg_t    cfg;
  sample_t s1_q;
  logic    s1_vld;
  logic    adv;
  result_t res;

  assign cfg_ready    = 1'b1;
  assign adv          = s1_vld && (!result_valid || !result_stall);
  assign sample_stall = s1_vld && !adv;

  ashk_core #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .en (adv),
    .cfg(cfg),
    .smp(s1_q),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.change_threshold <= CHANGE_THR_RST;
      cfg.count_threshold  <= COUNT_THR_RST;
      s1_vld               <= 1'b0;
      result_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CHANGE_THR: cfg.change_threshold <= cfg_data[AXIS_W-1:0];
          CFG_COUNT_THR:  cfg.count_threshold  <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) begin
        s1_vld <= 1'b1;
      end else if (adv) begin
        s1_vld <= 1'b0;
      end
      if (adv) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s1_q <= sample;
    end
    if (adv) begin
      result <= res;
    end
  end

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_vld && !adv |=> s1_vld && $stable(s1_q))
    else $error("pending item lost from input register");

  a_res_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_adv_fills: assert property (@(posedge clk) disable iff (rst)
    adv |=> result_valid)
    else $error("advanced item did not reach result register");

endmodule

FILE: rtl/ashk_core.sv
module ashk_core #(
  parameter int WINDOW_LEN = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ashk_pkg::cfg_t    cfg,
  input  ashk_pkg::sample_t smp,
  output ashk_pkg::result_t res
);
  import ashk_pkg::*;

  localparam int POS_W = $clog2(WINDOW_LEN);

  logic [AXIS_W-1:0]     mean_x, mean_y, mean_z;
  logic [AXIS_W-1:0]     mean_x_next, mean_y_next, mean_z_next;
  logic [WINDOW_LEN-1:0] flags, flags_next, flags_wr, pc_src;
  logic [POS_W-1:0]      pos, pos_next;
  logic                  all_zero, changed, shake;
  logic [AXIS_W-1:0]     dx, dy, dz;
  logic [AXIS_W:0]       sum_x, sum_y, sum_z;
  logic [COUNT_W-1:0]    count;

  function automatic logic [AXIS_W-1:0] abs_diff(input logic [AXIS_W-1:0] a,
                                                 input logic [AXIS_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    all_zero = (mean_x == '0) && (mean_y == '0) && (mean_z == '0);
    dx = abs_diff(mean_x, smp.accel_x);
    dy = abs_diff(mean_y, smp.accel_y);
    dz = abs_diff(mean_z, smp.accel_z);
    changed = (dx > cfg.change_threshold) || (dy > cfg.change_threshold) ||
              (dz > cfg.change_threshold);

    flags_wr = flags;
    flags_wr[pos] = changed;
    pc_src = all_zero ? flags : flags_wr;

    count = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      count = count + COUNT_W'(pc_src[i]);
    end

    shake = !all_zero && (count > cfg.count_threshold);

    sum_x = {1'b0, mean_x} + {1'b0, smp.accel_x};
    sum_y = {1'b0, mean_y} + {1'b0, smp.accel_y};
    sum_z = {1'b0, mean_z} + {1'b0, smp.accel_z};

    pos_next = (pos == POS_W'(WINDOW_LEN - 1)) ? '0 : pos + POS_W'(1);

    if (all_zero) begin
      mean_x_next = smp.accel_x;
      mean_y_next = smp.accel_y;
      mean_z_next = smp.accel_z;
      flags_next  = flags;
      pos_next    = pos;
    end else if (shake) begin
      mean_x_next = '0;
      mean_y_next = '0;
      mean_z_next = '0;
      flags_next  = '0;
    end else begin
      mean_x_next = sum_x[AXIS_W:1];
      mean_y_next = sum_y[AXIS_W:1];
      mean_z_next = sum_z[AXIS_W:1];
      flags_next  = flags_wr;
    end

    res.shake_detected = shake;
    res.change_count   = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_x <= '0;
      mean_y <= '0;
      mean_z <= '0;
      flags  <= '0;
      pos    <= '0;
    end else if (en) begin
      mean_x <= mean_x_next;
      mean_y <= mean_y_next;
      mean_z <= mean_z_next;
      flags  <= flags_next;
      pos    <= pos_next;
    end
  end

  a_shake_clears: assert property (@(posedge clk) disable iff (rst)
    en && res.shake_detected |=> flags == '0 && mean_x == '0 && mean_y == '0 && mean_z == '0)
    else $error("shake did not clear flags and means");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(WINDOW_LEN - 1))
    else $error("ring position out of range");

  a_load_holds: assert property (@(posedge clk) disable iff (rst)
    en && all_zero |=> $stable(flags) && $stable(pos))
    else $error("mean load moved the ring");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(flags) && $stable(pos) && $stable(mean_x))
    else $error("state changed without an item");

endmodule

FILE: sim/accel_shake_detector_tb.sv
`timescale 1ns / 1ps

module accel_shake_detector_tb;
  import ashk_pkg::*;

  localparam int WINDOW_LEN = 10;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  sample_t sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit idle_en = 1'b1;
  int mismatches = 0;
  int cycles = 0;

  // predictor state
  logic [AXIS_W-1:0] change_thr = CHANGE_THR_RST;
  logic [COUNT_W-1:0] count_thr = COUNT_THR_RST;
  logic [AXIS_W-1:0] mean_x = '0;
  logic [AXIS_W-1:0] mean_y = '0;
  logic [AXIS_W-1:0] mean_z = '0;
  logic [WINDOW_LEN-1:0] chg_flags = '0;
  int ring_pos = 0;
  result_t pending_results[$];

  accel_shake_detector #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [AXIS_W-1:0] axis_dev(logic [AXIS_W-1:0] a, logic [AXIS_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic result_t shake_step(sample_t s);
    result_t r;
    logic moved;
    int cnt;
    r = '0;
    if (mean_x == '0 && mean_y == '0 && mean_z == '0) begin
      mean_x = s.accel_x;
      mean_y = s.accel_y;
      mean_z = s.accel_z;
      r.change_count = COUNT_W'($countones(chg_flags));
    end else begin
      moved = axis_dev(mean_x, s.accel_x) > change_thr ||
              axis_dev(mean_y, s.accel_y) > change_thr ||
              axis_dev(mean_z, s.accel_z) > change_thr;
      chg_flags[ring_pos] = moved;
      ring_pos = (ring_pos == WINDOW_LEN - 1) ? 0 : ring_pos + 1;
      mean_x = AXIS_W'((17'(mean_x) + 17'(s.accel_x)) >> 1);
      mean_y = AXIS_W'((17'(mean_y) + 17'(s.accel_y)) >> 1);
      mean_z = AXIS_W'((17'(mean_z) + 17'(s.accel_z)) >> 1);
      cnt = $countones(chg_flags);
      if (cnt > int'(count_thr)) begin
        r.shake_detected = 1'b1;
        chg_flags = '0;
        mean_x = '0;
        mean_y = '0;
        mean_z = '0;
      end
      r.change_count = COUNT_W'(cnt);
    end
    return r;
  endfunction

  function automatic sample_t next_sample(sample_t base, logic [AXIS_W-1:0] thr);
    sample_t s;
    int spread;
    int pick;
    logic [AXIS_W-1:0] corner [4];
    corner = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
    spread = 2 * int'(thr) + 8;
    if (spread > 65535) spread = 65535;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      s.accel_x = base.accel_x + 16'($urandom_range(0, spread)) - 16'(spread / 2);
      s.accel_y = base.accel_y + 16'($urandom_range(0, spread)) - 16'(spread / 2);
      s.accel_z = base.accel_z + 16'($urandom_range(0, spread)) - 16'(spread / 2);
    end else if (pick < 85) begin
      s = {16'($urandom()), 16'($urandom()), 16'($urandom())};
    end else if (pick < 90) begin
      s = '0;
    end else begin
      s.accel_x = corner[$urandom_range(0, 3)];
      s.accel_y = corner[$urandom_range(0, 3)];
      s.accel_z = corner[$urandom_range(0, 3)];
    end
    return s;
  endfunction

  // prediction on accepted items, checking of accepted results
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $error("result item with no expectation waiting");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (result.shake_detected !== want.shake_detected) begin
            $error("shake_detected: expected %0d, got %0d", want.shake_detected,
                   result.shake_detected);
            mismatches++;
          end
          if (result.change_count !== want.change_count) begin
            $error("change_count: expected %0d, got %0d", want.change_count,
                   result.change_count);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHANGE_THR: change_thr = cfg_data;
          CFG_COUNT_THR: count_thr = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) pending_results.push_back(shake_step(sample));
    end
  end

  // receiver stalls in bursts
  always begin
    @(posedge clk);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      result_stall <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("accel_shake_detector_tb failed");
      $finish;
    end
  end

  task automatic send_sample(input sample_t s);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (sample_stall);
  endtask

  task automatic wait_results_done();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [AXIS_W-1:0] chg, input logic [COUNT_W-1:0] cnt);
    wait_results_done();
    write_reg(CFG_CHANGE_THR, chg);
    write_reg(CFG_COUNT_THR, {11'($urandom()), cnt});
  endtask

  task automatic run_phase(input logic [AXIS_W-1:0] chg, input logic [COUNT_W-1:0] cnt,
                           input int n_items);
    sample_t base;
    set_thresholds(chg, cnt);
    base = {16'($urandom()), 16'($urandom()), 16'($urandom())};
    repeat (n_items) send_sample(next_sample(base, chg));
  endtask

  // reset thresholds: zero samples, deviation at the threshold, a shake, reload
  task automatic test_directed();
    send_sample(sample_t'{16'd0, 16'd0, 16'd0});
    send_sample(sample_t'{16'd0, 16'd0, 16'd0});
    send_sample(sample_t'{16'd2000, 16'd2000, 16'd2000});
    send_sample(sample_t'{16'd3000, 16'd1000, 16'd2000});
    send_sample(sample_t'{16'd2500, 16'd1500, 16'd3001});
    send_sample(sample_t'{16'hFFFF, 16'h0000, 16'h8000});
    send_sample(sample_t'{16'h0000, 16'hFFFF, 16'h7FFF});
    send_sample(sample_t'{16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_sample(sample_t'{16'h0000, 16'h0000, 16'h0000});
    send_sample(sample_t'{16'h8000, 16'h7FFF, 16'h0001});
    send_sample(sample_t'{16'h0001, 16'h8000, 16'hFFFE});
  endtask

  // zero thresholds, count threshold beyond the flag count, ignored indexes
  task automatic test_threshold_extremes();
    set_thresholds(16'd0, 5'd0);
    send_sample(sample_t'{16'h8000, 16'h7FFF, 16'h0001});
    send_sample(sample_t'{16'h8000, 16'h7FFF, 16'h0001});
    send_sample(sample_t'{16'h8001, 16'h7FFF, 16'h0001});
    send_sample(sample_t'{16'hFFFF, 16'hFFFF, 16'hFFFF});
    set_thresholds(16'd0, 5'd16);
    for (int i = 0; i < 12; i++) begin
      send_sample(i % 2 ? sample_t'{16'h0000, 16'h5555, 16'hAAAA} :
                          sample_t'{16'hFFFF, 16'hAAAA, 16'h5555});
    end
    wait_results_done();
    write_reg(CFG_SPARE_2, 16'($urandom()));
    write_reg(CFG_SPARE_3, 16'($urandom()));
    set_thresholds(16'hFFFF, 5'd31);
    for (int i = 0; i < 6; i++) send_sample(sample_t'{16'hFFFF, 16'h0000, 16'hFFFF});
  endtask

  task automatic test_random_mix();
    run_phase(16'd1000, 5'd4, 220);
    run_phase(16'd0, 5'd0, 150);
    run_phase(16'hFFFF, 5'd16, 100);
    run_phase(16'd50, 5'd2, 220);
    run_phase(16'd300, 5'd9, 220);
    run_phase(16'($urandom()), 5'd31, 150);
    run_phase(16'd5000, 5'd1, 220);
    run_phase(16'($urandom_range(0, 3000)), 5'($urandom_range(0, 16)), 220);
  endtask

  task automatic test_steady_stream();
    idle_en = 1'b0;
    run_phase(16'd800, 5'd3, 250);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_threshold_extremes();
    test_random_mix();
    test_steady_stream();
    wait_results_done();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("accel_shake_detector_tb passed");
    end else begin
      $display("accel_shake_detector_tb failed");
    end
    $finish;
  end

endmodule
